FILE: hw/rtl/ecgc_pkg.sv
// Shared constants and command/status structs for the ECG sample conditioner.
// No dependencies.
package ecgc_pkg;
    localparam int DEF_WINDOW_LEN = 16;
    localparam int DEF_BATCH_LEN  = 16;
    localparam int SAMPLE_W = 24;
    localparam int UV_W     = 22;
    localparam int SCALE_W  = 20;
    localparam int DEB_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECG_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESP_SCALE = 2'd2;
    localparam int FULL_SCALE = 8388607;
    localparam int PROD_W = SAMPLE_W + SCALE_W + 1;   // signed product
    localparam int DIV_W = 45;                        // magnitude bits in the divider

    // Selects the current pass: the divider's average or one channel scaling.
    localparam logic [2:0] SEL_AVG   = 3'd0;
    localparam logic [2:0] SEL_RESP  = 3'd1;
    localparam logic [2:0] SEL_LEAD1 = 3'd2;
    localparam logic [2:0] SEL_LEAD2 = 3'd3;
    localparam logic [2:0] SEL_CHEST = 3'd4;

    typedef struct packed {
        logic       load;      // latch input beat, update window
        logic       div_start; // start a division
        logic [2:0] sel;       // operand selection, result destination
        logic       out_load;  // present result
    } ecgc_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
    } ecgc_stat_t;
endpackage

FILE: hw/rtl/ecgc_ctrl.sv
// Sequencer for the ECG sample conditioner: starts the divider for the
// average, then steps through the four channel scalings. Uses ecgc_pkg.
module ecgc_ctrl
    import ecgc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       out_pending,
    input  logic       out_free,
    input  ecgc_stat_t stat,
    output ecgc_cmd_t  cmd
);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [2:0] sel_reg, sel_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        sel_next = sel_reg;
        cmd = '0;
        cmd.sel = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    sel_next = SEL_AVG;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (stat.div_done)
                begin
                    if (sel_reg == SEL_CHEST)
                        state_next = ST_OUT;
                    else
                    begin
                        sel_next = sel_reg + 3'd1;
                        state_next = ST_START;
                    end
                end
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_pending || out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg <= SEL_AVG;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg <= sel_next;
        end
    end

    a_start_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> state_reg == ST_WAIT) else $error("start not followed by wait");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_busy |-> in_stall) else $error("input taken while dividing");
    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> !in_stall) else $error("no return to idle");
endmodule

FILE: hw/rtl/ecgc_divider.sv
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// Uses ecgc_pkg.
module ecgc_divider
    import ecgc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DIV_W:0]   dividend,
    input  logic [DIV_W-1:0]        divisor,
    output logic signed [DIV_W:0]   quotient,
    output logic                    busy,
    output logic                    done
);
    localparam int CNT_W = $clog2(DIV_W + 1);
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   mag;

    assign mag = dividend[DIV_W] ? -dividend : dividend;
    assign trial = {rem_reg, quo_reg[DIV_W-1]} - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= mag[DIV_W-1:0];
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dividend[DIV_W];
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_W])
            begin
                rem_reg <= trial[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign busy = busy_reg;
    assign done = done_reg;
endmodule

FILE: hw/rtl/ecgc_datapath.sv
// Datapath: window store and running sum, scaling multiplier, averaging divider,
// lead-off debounce and batch counter. Uses ecgc_pkg and ecgc_divider.
module ecgc_datapath
    import ecgc_pkg::*;
#(
    parameter int WINDOW_LEN = DEF_WINDOW_LEN,
    parameter int BATCH_LEN  = DEF_BATCH_LEN
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ecgc_cmd_t                  cmd,
    output ecgc_stat_t                 stat,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [SAMPLE_W-1:0] resp_raw,
    input  logic signed [SAMPLE_W-1:0] lead_one_raw,
    input  logic signed [SAMPLE_W-1:0] lead_two_raw,
    input  logic signed [SAMPLE_W-1:0] chest_raw,
    input  logic [SAMPLE_W-1:0]        status_word,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [UV_W-1:0]     resp_uv,
    output logic signed [UV_W-1:0]     lead_one_uv,
    output logic signed [UV_W-1:0]     lead_two_uv,
    output logic signed [UV_W-1:0]     chest_uv,
    output logic [3:0]                 electrode_off_mask,
    output logic                       batch_last
);
    localparam int POS_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W = SAMPLE_W + POS_W + 1;
    localparam int BP_W  = (BATCH_LEN > 1) ? $clog2(BATCH_LEN) : 1;
    localparam int FS_SHIFT = $clog2(FULL_SCALE);
    localparam int SQ_W  = PROD_W - FS_SHIFT;

    logic [DEB_W-1:0]   debounce_reg;
    logic [SCALE_W-1:0] ecg_scale_reg, resp_scale_reg;

    logic signed [SAMPLE_W-1:0] win_reg [WINDOW_LEN];
    logic [WINDOW_LEN-1:0]      win_valid_reg;
    logic [POS_W-1:0]           pos_reg;
    logic                       full_reg;
    logic signed [SUM_W-1:0]    total_reg;
    logic signed [SAMPLE_W-1:0] l1_reg, l2_reg, ch_reg;
    logic signed [SAMPLE_W-1:0] avg_reg;
    logic [CNT_W-1:0]           n_reg;
    logic [3:0]                 cand_reg, pub_reg;
    logic [DEB_W-1:0]           run_reg;
    logic [BP_W-1:0]            bpos_reg;
    logic                       blast_reg;
    logic signed [UV_W-1:0]     r_resp_reg, r_l1_reg, r_l2_reg, r_ch_reg;
    logic                       ov_reg;
    logic                       sc1_reg, sc2_reg;
    logic [SQ_W-1:0]            sq0_reg;
    logic [FS_SHIFT:0]          srem_reg;
    logic                       sneg_reg;

    logic signed [SAMPLE_W-1:0] old_s;
    logic [POS_W-1:0]           pos_inc;
    logic                       wrap;
    logic [3:0]                 raw_m;
    logic [DEB_W-1:0]           run_inc;
    logic signed [SAMPLE_W-1:0] mul_a;
    logic [SCALE_W-1:0]         mul_b;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]          prod_mag;
    logic [SQ_W-1:0]            sq;
    logic signed [UV_W-1:0]     scaled;
    logic                       div_go;
    logic signed [DIV_W:0]      dvd;
    logic [DIV_W-1:0]           dvs;
    logic signed [DIV_W:0]      quo;
    logic                       dbusy, ddone;

    assign old_s = win_valid_reg[pos_reg] ? win_reg[pos_reg] : '0;
    assign wrap = (pos_reg == POS_W'(WINDOW_LEN - 1));
    assign pos_inc = wrap ? '0 : pos_reg + 1'b1;
    assign raw_m = {status_word[15], status_word[14], status_word[13], status_word[5]};
    assign run_inc = run_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEB_W'(50);
            ecg_scale_reg <= SCALE_W'(400000);
            resp_scale_reg <= SCALE_W'(600000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE:   debounce_reg <= cfg_data[DEB_W-1:0];
                REG_ECG_SCALE:  ecg_scale_reg <= cfg_data;
                REG_RESP_SCALE: resp_scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= '0;
            pos_reg <= '0;
            full_reg <= 1'b0;
            total_reg <= '0;
            cand_reg <= '0;
            pub_reg <= '0;
            run_reg <= '0;
            bpos_reg <= '0;
            blast_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            win_valid_reg[pos_reg] <= 1'b1;
            pos_reg <= pos_inc;
            if (wrap)
                full_reg <= 1'b1;
            total_reg <= total_reg - SUM_W'(old_s) + SUM_W'(resp_raw);
            if (raw_m != cand_reg)
            begin
                cand_reg <= raw_m;
                run_reg <= '0;
            end
            else if (raw_m != pub_reg)
            begin
                run_reg <= run_inc;
                if (run_inc >= debounce_reg)
                    pub_reg <= raw_m;
            end
            if (bpos_reg == BP_W'(BATCH_LEN - 1))
            begin
                bpos_reg <= '0;
                blast_reg <= 1'b1;
            end
            else
            begin
                bpos_reg <= bpos_reg + 1'b1;
                blast_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            win_reg[pos_reg] <= resp_raw;
            l1_reg <= lead_one_raw;
            l2_reg <= lead_two_raw;
            ch_reg <= chest_raw;
            n_reg <= (full_reg || wrap) ? CNT_W'(WINDOW_LEN) : CNT_W'(pos_inc);
        end
    end

    // multiplier operands; resp uses the average computed in the first pass
    always_comb
    begin
        mul_a = l1_reg;
        mul_b = ecg_scale_reg;
        case (cmd.sel)
            SEL_RESP:  begin mul_a = avg_reg; mul_b = resp_scale_reg; end
            SEL_LEAD1: mul_a = l1_reg;
            SEL_LEAD2: mul_a = l2_reg;
            SEL_CHEST: mul_a = ch_reg;
            default:   mul_a = l1_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * $signed({1'b0, mul_b});
    end

    // divide by 2^23-1: q0 = mag >> 23 leaves remainder low + q0, which needs
    // at most one correction step
    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign sq = sq0_reg + SQ_W'(srem_reg >= (FS_SHIFT+1)'(FULL_SCALE));
    assign scaled = sneg_reg ? -$signed(UV_W'(sq)) : $signed(UV_W'(sq));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc1_reg <= 1'b0;
            sc2_reg <= 1'b0;
        end
        else
        begin
            sc1_reg <= cmd.div_start && (cmd.sel != SEL_AVG);
            sc2_reg <= sc1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sc1_reg)
        begin
            sq0_reg <= prod_mag[PROD_W-1:FS_SHIFT];
            srem_reg <= {1'b0, prod_mag[FS_SHIFT-1:0]}
                        + (FS_SHIFT+1)'(prod_mag[PROD_W-1:FS_SHIFT]);
            sneg_reg <= prod_reg[PROD_W-1];
        end
    end

    assign div_go = cmd.div_start && (cmd.sel == SEL_AVG);
    assign dvd = (DIV_W+1)'(total_reg);
    assign dvs = DIV_W'(n_reg);

    ecgc_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_go),
        .dividend(dvd), .divisor(dvs), .quotient(quo), .busy(dbusy), .done(ddone)
    );

    always_ff @(posedge clk)
    begin
        if (ddone)
            avg_reg <= quo[SAMPLE_W-1:0];
        if (sc2_reg)
        begin
            case (cmd.sel)
                SEL_RESP:  r_resp_reg <= scaled;
                SEL_LEAD1: r_l1_reg <= scaled;
                SEL_LEAD2: r_l2_reg <= scaled;
                SEL_CHEST: r_ch_reg <= scaled;
                default: ;
            endcase
        end
        if (cmd.out_load)
        begin
            resp_uv <= r_resp_reg;
            lead_one_uv <= r_l1_reg;
            lead_two_uv <= r_l2_reg;
            chest_uv <= r_ch_reg;
            electrode_off_mask <= pub_reg;
            batch_last <= blast_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.out_load)
            ov_reg <= 1'b1;
        else if (!out_stall)
            ov_reg <= 1'b0;
    end

    assign out_valid = ov_reg;
    assign stat.div_busy = dbusy;
    assign stat.div_done = ddone | sc2_reg;
endmodule

FILE: hw/rtl/ecg_sample_conditioner.sv
// ECG sample conditioner top level: controller plus datapath.
// Depends on ecgc_pkg, ecgc_ctrl, ecgc_datapath.
//
// Usage: one input beat (in_valid/in_stall) carries a respiration sample,
// three lead samples and the converter status word. Each beat yields one
// result beat (out_valid/out_stall): averaged respiration and the three
// leads in microvolts, the debounced electrode-off mask and a batch flag.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), used
// only while idle: 0 debounce count, 1 lead scale, 2 respiration scale.
// Sequence: the 45-step serial divider forms the window average, then each
// of the four scalings runs through multiply, reduce and correct steps; the
// result is then loaded into the output register, and the next beat is taken
// only once the controller is back in idle, so beats never overlap.
// Reset clears the window, debounce and batch state at once (per-entry
// valid bits) and restores the registers.
// A stalled result holds in the output register; the next result waits in
// the controller until that register frees, and the input stalls meanwhile.
module ecg_sample_conditioner
    import ecgc_pkg::*;
#(
    parameter int WINDOW_LEN = DEF_WINDOW_LEN,
    parameter int BATCH_LEN  = DEF_BATCH_LEN
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] resp_raw,
    input  logic signed [SAMPLE_W-1:0] lead_one_raw,
    input  logic signed [SAMPLE_W-1:0] lead_two_raw,
    input  logic signed [SAMPLE_W-1:0] chest_raw,
    input  logic [SAMPLE_W-1:0]        status_word,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [UV_W-1:0]     resp_uv,
    output logic signed [UV_W-1:0]     lead_one_uv,
    output logic signed [UV_W-1:0]     lead_two_uv,
    output logic signed [UV_W-1:0]     chest_uv,
    output logic [3:0]                 electrode_off_mask,
    output logic                       batch_last
);
    ecgc_cmd_t  cmd;
    ecgc_stat_t stat;

    ecgc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_pending(out_valid), .out_free(!out_stall), .stat(stat), .cmd(cmd)
    );

    ecgc_datapath #(.WINDOW_LEN(WINDOW_LEN), .BATCH_LEN(BATCH_LEN)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .resp_raw(resp_raw), .lead_one_raw(lead_one_raw),
        .lead_two_raw(lead_two_raw), .chest_raw(chest_raw),
        .status_word(status_word), .out_valid(out_valid), .out_stall(out_stall),
        .resp_uv(resp_uv), .lead_one_uv(lead_one_uv), .lead_two_uv(lead_two_uv),
        .chest_uv(chest_uv), .electrode_off_mask(electrode_off_mask),
        .batch_last(batch_last)
    );
endmodule

FILE: tb/sv/tb_top.sv
// Testbench for ecg_sample_conditioner: drives sample beats and config writes, predicts
// averaged/scaled outputs, debounced electrode mask and batch flag, and checks each result.
// Depends on ecgc_pkg and the ecg_sample_conditioner RTL.

class ecg_expect_board;
    int unsigned debounce_cnt;
    int unsigned lead_scale;
    int unsigned resp_scale;
    int          window_vals[16];
    int unsigned window_idx;
    bit          window_filled;
    longint      window_sum;
    bit [3:0]    cand_mask;
    bit [3:0]    pub_mask;
    bit [15:0]   run_len;
    int unsigned batch_idx;
    bit [92:0]   pending[$];
    int          mismatches;

    function new();
        debounce_cnt = 50;
        lead_scale = 400000;
        resp_scale = 600000;
        foreach (window_vals[i]) window_vals[i] = 0;
        window_idx = 0;
        window_filled = 0;
        window_sum = 0;
        cand_mask = 0;
        pub_mask = 0;
        run_len = 0;
        batch_idx = 0;
        mismatches = 0;
    endfunction

    function bit [21:0] to_microvolt(longint s, int unsigned scale);
        longint r;
        r = (s * longint'(scale)) / 64'sd8388607;
        return r[21:0];
    endfunction

    function void note_sample(logic signed [23:0] resp, logic signed [23:0] l1,
                              logic signed [23:0] l2, logic signed [23:0] ch,
                              logic [23:0] st);
        longint avg;
        int unsigned n;
        bit [3:0] raw;
        bit last;
        window_sum -= window_vals[window_idx];
        window_vals[window_idx] = resp;
        window_sum += resp;
        window_idx = (window_idx + 1) % 16;
        if (!window_filled && window_idx == 0)
            window_filled = 1;
        n = window_filled ? 16 : (window_idx != 0 ? window_idx : 1);
        avg = window_sum / longint'(n);
        raw = {st[15], st[14], st[13], st[5]};
        if (raw != cand_mask)
        begin
            cand_mask = raw;
            run_len = 0;
        end
        else if (raw != pub_mask)
        begin
            run_len = run_len + 16'd1;
            if (run_len >= debounce_cnt)
                pub_mask = raw;
        end
        batch_idx++;
        last = 0;
        if (batch_idx >= 16)
        begin
            batch_idx = 0;
            last = 1;
        end
        pending.push_back({to_microvolt(avg, resp_scale), to_microvolt(l1, lead_scale),
                           to_microvolt(l2, lead_scale), to_microvolt(ch, lead_scale),
                           pub_mask, last});
    endfunction

    function void check_result(bit [92:0] got);
        bit [92:0] exp;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat %h", got);
            return;
        end
        exp = pending.pop_front();
        if (exp != got)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch: exp resp %h l1 %h l2 %h ch %h mask %h last %b",
                    exp[92:71], exp[70:49], exp[48:27], exp[26:5], exp[4:1], exp[0]);
                $display("          got resp %h l1 %h l2 %h ch %h mask %h last %b",
                    got[92:71], got[70:49], got[48:27], got[26:5], got[4:1], got[0]);
            end
        end
    endfunction
endclass

module tb_top;
    import ecgc_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [SAMPLE_W-1:0] resp_raw, lead_one_raw, lead_two_raw, chest_raw;
    logic [SAMPLE_W-1:0] status_word;
    logic out_valid;
    logic out_stall;
    logic signed [UV_W-1:0] resp_uv, lead_one_uv, lead_two_uv, chest_uv;
    logic [3:0] electrode_off_mask;
    logic batch_last;

    ecg_expect_board board;
    int idle_pct;
    int hold_off_cycles;

    ecg_sample_conditioner dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100000000;
        $display("tb_top: FAIL");
        $finish;
    end

    // check results at the rising edge
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result({resp_uv, lead_one_uv, lead_two_uv, chest_uv,
                                electrode_off_mask, batch_last});

    // receiver side: random stall, plus requested long hold-off
    initial
    begin
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                out_stall <= 1;
                hold_off_cycles--;
            end
            else
                out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we <= 0;
        if (idx == REG_DEBOUNCE) board.debounce_cnt = val & 32'hFFFF;
        else if (idx == REG_ECG_SCALE) board.lead_scale = val & 32'hFFFFF;
        else if (idx == REG_RESP_SCALE) board.resp_scale = val & 32'hFFFFF;
    endtask

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_sample(logic signed [23:0] r, logic signed [23:0] a,
                               logic signed [23:0] b, logic signed [23:0] c,
                               logic [23:0] st);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        resp_raw <= r;
        lead_one_raw <= a;
        lead_two_raw <= b;
        chest_raw <= c;
        status_word <= st;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_sample(r, a, b, c, st);
        @(negedge clk);
    endtask

    task automatic send_random(int count, int mask_bias);
        logic [23:0] st;
        for (int i = 0; i < count; i++)
        begin
            st = SAMPLE_W'($urandom);
            // keep the electrode bits steady in mask_bias percent of samples so debounce publishes
            if ($urandom_range(99) < mask_bias)
            begin
                st[15:13] = 3'b101;
                st[5] = 1'b0;
            end
            send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                        SAMPLE_W'($urandom), st);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 0;
        while (board.pending.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (300) @(negedge clk);
    endtask

    initial
    begin
        board = new();
        idle_pct = 0;
        hold_off_cycles = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = REG_DEBOUNCE;
        cfg_data = 0;
        in_valid = 0;
        resp_raw = 0;
        lead_one_raw = 0;
        lead_two_raw = 0;
        chest_raw = 0;
        status_word = 0;
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: extremes under reset config, window fill, mask changes
        send_sample(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'h000000);
        send_sample(24'sh800000, 24'sh800000, 24'sh7FFFFF, -24'sd1, 24'hFFFFFF);
        send_sample(24'sh000001, 24'sd1, -24'sd1, 24'sh7FFFFF, 24'h00F0F0);
        drain();
        write_reg(REG_DEBOUNCE, 0);
        write_reg(REG_ECG_SCALE, 20'hFFFFF);
        write_reg(REG_RESP_SCALE, 0);
        for (int i = 0; i < 6; i++)
            send_sample(24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh800000,
                        (i < 3) ? 24'h00E020 : 24'h000000);
        drain();
        write_reg(REG_DEBOUNCE, 1);
        write_reg(REG_ECG_SCALE, 0);
        write_reg(REG_RESP_SCALE, 20'hFFFFF);
        for (int i = 0; i < 12; i++)
            send_sample(24'sh7FFFFF, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                        SAMPLE_W'($urandom), (i % 4 < 2) ? 24'h002000 : 24'h008020);
        drain();

        // random phases with different settings and idling
        idle_pct = 20;
        write_reg(REG_DEBOUNCE, 3);
        write_reg(REG_ECG_SCALE, $urandom_range(20'hFFFFF));
        send_random(200, 90);
        // long receiver hold-off while sender keeps offering
        hold_off_cycles = 2000;
        send_random(20, 50);
        drain();
        idle_pct = 0;
        write_reg(REG_DEBOUNCE, 16'hFFFF);
        write_reg(REG_RESP_SCALE, $urandom_range(20'hFFFFF));
        send_random(150, 95);
        drain();
        idle_pct = 20;
        write_reg(REG_DEBOUNCE, $urandom_range(1, 20));
        write_reg(REG_ECG_SCALE, 400000);
        write_reg(REG_RESP_SCALE, 600000);
        send_random(450, 85);
        drain();

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule

FILE: ecg_sample_conditioner.f
hw/rtl/ecgc_pkg.sv
hw/rtl/ecgc_ctrl.sv
hw/rtl/ecgc_divider.sv
hw/rtl/ecgc_datapath.sv
hw/rtl/ecg_sample_conditioner.sv
tb/sv/tb_top.sv
